// ===== sv/ssmc_pkg.sv =====
package ssmc_pkg;

  // Operating modes, coded as on the result mode field
  typedef enum logic [1:0] {
    MODE_SCAN   = 2'd0,
    MODE_TRANS  = 2'd1,
    MODE_MANUAL = 2'd2
  } mode_t;

  // Input word
  typedef struct packed {
    logic       tick;
    logic       button_level;
    logic [5:0] encoder_angle;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [11:0] servo_position;
    mode_t              mode;
    logic               position_changed;
  } out_word_t;

  localparam int unsigned ANGLE_W   = 6;
  localparam int unsigned ANGLE_CNT = 46;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned STEP_W    = 7;
  localparam int unsigned SUM_W     = 13;

  localparam logic [ANGLE_W-1:0]       ANGLE_MAX    = 6'd45;
  localparam logic [STEP_W-1:0]        STEP_RESET   = 7'd10;
  localparam logic signed [SUM_W-1:0]  POS_BOUND    = 13'sd1000;
  localparam logic signed [SUM_W-1:0]  POS_SAT_HIGH = 13'sd1100;
  localparam logic signed [SUM_W-1:0]  POS_SAT_LOW  = -13'sd100;
  localparam logic signed [SUM_W-1:0]  MATCH_SPAN   = 13'sd9;

  // Manual position per encoder angle: floor(angle * 1000 / 45)
  localparam logic [9:0] MANUAL_POS_TBL [ANGLE_CNT] = '{
    10'd0,   10'd22,  10'd44,  10'd66,  10'd88,  10'd111, 10'd133, 10'd155,
    10'd177, 10'd200, 10'd222, 10'd244, 10'd266, 10'd288, 10'd311, 10'd333,
    10'd355, 10'd377, 10'd400, 10'd422, 10'd444, 10'd466, 10'd488, 10'd511,
    10'd533, 10'd555, 10'd577, 10'd600, 10'd622, 10'd644, 10'd666, 10'd688,
    10'd711, 10'd733, 10'd755, 10'd777, 10'd800, 10'd822, 10'd844, 10'd866,
    10'd888, 10'd911, 10'd933, 10'd955, 10'd977, 10'd1000
  };

  // Transition target times ten: floor(angle * 100 / 45) * 10
  localparam logic [9:0] TRANS_TGT_TBL [ANGLE_CNT] = '{
    10'd0,   10'd20,  10'd40,  10'd60,  10'd80,  10'd110, 10'd130, 10'd150,
    10'd170, 10'd200, 10'd220, 10'd240, 10'd260, 10'd280, 10'd310, 10'd330,
    10'd350, 10'd370, 10'd400, 10'd420, 10'd440, 10'd460, 10'd480, 10'd510,
    10'd530, 10'd550, 10'd570, 10'd600, 10'd620, 10'd640, 10'd660, 10'd680,
    10'd710, 10'd730, 10'd750, 10'd770, 10'd800, 10'd820, 10'd840, 10'd860,
    10'd880, 10'd910, 10'd930, 10'd950, 10'd970, 10'd1000
  };

endpackage

// ===== sv/servo_sweep_manual_mode_controller_top.sv =====
// Servo sweep / manual mode controller.
// Input channel (in_valid, in_stall, in_word): one word per control pass,
// carrying the timer tick flag, the button level and the encoder angle.
// Result channel (out_valid, out_stall, out_word): one word per input word,
// with the servo position, the mode and a position-changed flag.
// Config channel (cfg_valid, cfg_ready, cfg_sweep_step): sets the sweep
// step; cfg_ready is always high. Write it only while the block is idle.
// An accepted input word goes into the input register, then one pass of logic
// writes its result into the result register.
// Throughput: one word per cycle while out_stall is low; the whole pass is table
// lookups, one 13-bit add with saturation and a range compare.
// Reset (rst_n low, synchronous): scan mode at position 0, sweep step 10,
// no tick pending, both channels empty.
// When out_stall is high the result register holds; one more input word is
// still taken if the input register is empty, then in_stall rises until the
// result is taken.
module servo_sweep_manual_mode_controller_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssmc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ssmc_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_sweep_step
);
  import ssmc_pkg::*;

  // Pipeline registers
  logic                     in_valid_r;
  in_word_t                 in_word_r;
  logic                     out_valid_r;
  out_word_t                out_word_r;

  // Block state
  logic [STEP_W-1:0]        step_r;
  logic signed [POS_W-1:0]  pos_r,       pos_nxt;
  logic                     up_r,        up_nxt;
  logic                     tick_r,      tick_nxt;
  mode_t                    mode_r,      mode_nxt;
  logic                     btn_r;
  logic [ANGLE_W-1:0]       capt_r,      capt_nxt;
  logic [ANGLE_W-1:0]       last_ang_r,  last_ang_nxt;
  logic                     ang_vld_r,   ang_vld_nxt;

  logic                     advance;
  logic [ANGLE_W-1:0]       angle;
  logic                     btn_edge;
  logic signed [SUM_W-1:0]  pos_ext;
  logic signed [SUM_W-1:0]  step_ext;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_sat;
  logic                     at_bound;
  logic                     up_turn;
  logic signed [SUM_W-1:0]  tgt_lo;
  logic signed [SUM_W-1:0]  tgt_hi;
  logic signed [SUM_W-1:0]  pos_chk;
  logic [9:0]               tgt10;

  // Handshake
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cfg_ready = 1'b1;

  // Encoder saturation and button falling edge
  assign angle    = (in_word_r.encoder_angle > ANGLE_MAX) ? ANGLE_MAX
                                                           : in_word_r.encoder_angle;
  assign btn_edge = btn_r && !in_word_r.button_level;

  // One sweep step: reverse at the bounds, then step and clamp
  assign pos_ext  = SUM_W'(pos_r);
  assign step_ext = signed'({{(SUM_W-STEP_W){1'b0}}, step_r});
  assign at_bound = (pos_ext >= POS_BOUND) || (pos_ext <= signed'(SUM_W'(0)));
  assign up_turn  = up_r ^ at_bound;
  assign sum      = up_turn ? (pos_ext + step_ext) : (pos_ext - step_ext);

  always_comb begin
    if (sum > POS_SAT_HIGH) begin
      sum_sat = POS_SAT_HIGH;
    end else if (sum < POS_SAT_LOW) begin
      sum_sat = POS_SAT_LOW;
    end else begin
      sum_sat = sum;
    end
  end

  // Control pass
  always_comb begin
    tick_nxt     = tick_r | in_word_r.tick;
    mode_nxt     = mode_r;
    capt_nxt     = capt_r;
    pos_nxt      = pos_r;
    up_nxt       = up_r;
    last_ang_nxt = last_ang_r;
    ang_vld_nxt  = ang_vld_r;

    // button edge: scan -> transition (capture), manual -> scan
    if (btn_edge) begin
      unique case (mode_r)
        MODE_SCAN: begin
          capt_nxt = angle;
          mode_nxt = MODE_TRANS;
        end
        MODE_MANUAL: mode_nxt = MODE_SCAN;
        default:     mode_nxt = mode_r;
      endcase
    end

    unique case (mode_nxt)
      MODE_MANUAL: begin
        if (!ang_vld_r || (angle != last_ang_r)) begin
          last_ang_nxt = angle;
          ang_vld_nxt  = 1'b1;
          pos_nxt      = signed'({2'b00, MANUAL_POS_TBL[angle]});
        end
      end
      default: begin
        if (tick_nxt) begin
          tick_nxt = 1'b0;
          up_nxt   = up_turn;
          pos_nxt  = sum_sat[POS_W-1:0];
        end
      end
    endcase

    // transition ends when position / 10 equals the captured target
    tgt10   = TRANS_TGT_TBL[capt_nxt];
    tgt_hi  = signed'({3'b000, tgt10}) + MATCH_SPAN;
    tgt_lo  = (tgt10 == '0) ? -MATCH_SPAN : signed'({3'b000, tgt10});
    pos_chk = SUM_W'(pos_nxt);
    if ((mode_nxt == MODE_TRANS) && (pos_chk >= tgt_lo) && (pos_chk <= tgt_hi)) begin
      mode_nxt = MODE_MANUAL;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= STEP_RESET;
      pos_r       <= '0;
      up_r        <= 1'b0;
      tick_r      <= 1'b0;
      mode_r      <= MODE_SCAN;
      btn_r       <= 1'b0;
      capt_r      <= '0;
      ang_vld_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_sweep_step;
      end
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        pos_r       <= pos_nxt;
        up_r        <= up_nxt;
        tick_r      <= tick_nxt;
        mode_r      <= mode_nxt;
        btn_r       <= in_word_r.button_level;
        capt_r      <= capt_nxt;
        ang_vld_r   <= ang_vld_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
    if (advance) begin
      last_ang_r                  <= last_ang_nxt;
      out_word_r.servo_position   <= pos_nxt;
      out_word_r.mode             <= mode_nxt;
      out_word_r.position_changed <= (pos_nxt != pos_r);
    end
  end

endmodule
